FILE: rtl/core/lfps_pkg.sv
package lfps_pkg;

  localparam int ERR_W   = 9;
  localparam int SUM_W   = 16;
  localparam int DERR_W  = 10;
  localparam int TERM_W  = 27;
  localparam int MAG_W   = 26;
  localparam int RECIP_W = MAG_W + 1;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int DRV_W   = MAG_W + 2;
  localparam int CFG_W   = 16;

  localparam int SCALE_DIVISOR_DEF = 64;
  localparam int TURN_DEADBAND     = 5;

  localparam logic [14:0] INTEG_LIMIT_RST = 15'd1000;
  localparam logic [6:0]  BASE_SPEED_RST  = 7'd30;
  localparam logic [7:0]  NEAR_WHITE_RST  = 8'd60;
  localparam logic [7:0]  NEAR_BLACK_RST  = 8'd180;
  localparam logic [15:0] LOST_LIMIT_RST  = 16'd100;

  localparam logic signed [7:0] DRIVE_MAX = 8'sd100;
  localparam logic signed [7:0] DRIVE_MIN = -8'sd100;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_TRACK = 2'd1,
    MODE_LOST  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    TURN_FWD   = 2'd0,
    TURN_RIGHT = 2'd1,
    TURN_LEFT  = 2'd2
  } turn_t;

  typedef enum logic [2:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_INTEG_GAIN  = 3'd1,
    CFG_DERIV_GAIN  = 3'd2,
    CFG_INTEG_LIMIT = 3'd3,
    CFG_BASE_SPEED  = 3'd4,
    CFG_NEAR_WHITE  = 3'd5,
    CFG_NEAR_BLACK  = 3'd6,
    CFG_LOST_LIMIT  = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [9:0]  prop_gain;
    logic [9:0]  integ_gain;
    logic [9:0]  deriv_gain;
    logic [14:0] integ_limit;
    logic [6:0]  base_speed;
    logic [7:0]  near_white;
    logic [7:0]  near_black;
    logic [15:0] lost_limit;
  } cfg_t;

  typedef struct packed {
    logic                      pid;
    mode_t                     mode;
    logic signed [ERR_W-1:0]   err;
    logic signed [SUM_W-1:0]   sum;
    logic signed [DERR_W-1:0]  derr;
  } s1_t;

  typedef struct packed {
    logic              pid;
    mode_t             mode;
    logic              neg;
    logic [MAG_W-1:0]  quot;
  } res_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } math_load_t;

endpackage

FILE: rtl/core/lfps_ctrl.sv
module lfps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              action,
  input  logic [7:0]        left_sample,
  input  logic [7:0]        right_sample,
  input  lfps_pkg::cfg_t    cfg,
  output lfps_pkg::mode_t   mode,
  output lfps_pkg::s1_t     s1
);

  logic [15:0]                              white_run;
  logic signed [lfps_pkg::SUM_W-1:0]        error_sum;
  logic signed [lfps_pkg::ERR_W-1:0]        prev_error;

  lfps_pkg::mode_t                          mode_next;
  logic [15:0]                              white_run_next;
  logic signed [lfps_pkg::SUM_W-1:0]        error_sum_next;
  logic signed [lfps_pkg::ERR_W-1:0]        prev_error_next;
  lfps_pkg::s1_t                            s1_next;

  logic [15:0]                              run_inc;
  logic                                     both_white;
  logic                                     any_black;
  logic signed [lfps_pkg::ERR_W-1:0]        err;
  logic signed [lfps_pkg::SUM_W:0]          sum_raw;
  logic signed [lfps_pkg::SUM_W:0]          lim;
  logic signed [lfps_pkg::SUM_W-1:0]        sum_clamped;

  assign run_inc    = (white_run == 16'hFFFF) ? white_run : white_run + 16'd1;
  assign both_white = (left_sample < cfg.near_white) && (right_sample < cfg.near_white);
  assign any_black  = (left_sample > cfg.near_black) || (right_sample > cfg.near_black);
  assign err        = signed'({1'b0, left_sample}) - signed'({1'b0, right_sample});
  assign sum_raw    = (lfps_pkg::SUM_W+1)'(error_sum) + (lfps_pkg::SUM_W+1)'(err);
  assign lim        = signed'({2'b00, cfg.integ_limit});

  always_comb begin
    if (sum_raw > lim) begin
      sum_clamped = lfps_pkg::SUM_W'(lim);
    end else if (sum_raw < -lim) begin
      sum_clamped = lfps_pkg::SUM_W'(-lim);
    end else begin
      sum_clamped = lfps_pkg::SUM_W'(sum_raw);
    end
  end

  always_comb begin
    mode_next       = mode;
    white_run_next  = white_run;
    error_sum_next  = error_sum;
    prev_error_next = prev_error;
    s1_next.pid     = 1'b0;
    s1_next.err     = err;
    s1_next.sum     = sum_clamped;
    s1_next.derr    = lfps_pkg::DERR_W'(err) - lfps_pkg::DERR_W'(prev_error);
    if (action) begin
      if (mode == lfps_pkg::MODE_IDLE) begin
        mode_next      = lfps_pkg::MODE_TRACK;
        white_run_next = '0;
      end else begin
        mode_next = lfps_pkg::MODE_IDLE;
      end
    end else begin
      case (mode)
        lfps_pkg::MODE_TRACK: begin
          if (both_white) begin
            white_run_next = run_inc;
          end else begin
            white_run_next = '0;
          end
          if (both_white && (run_inc > cfg.lost_limit)) begin
            mode_next = lfps_pkg::MODE_LOST;
          end else begin
            s1_next.pid     = 1'b1;
            error_sum_next  = sum_clamped;
            prev_error_next = err;
          end
        end
        lfps_pkg::MODE_LOST: begin
          if (any_black) begin
            mode_next = lfps_pkg::MODE_TRACK;
          end
        end
        default: begin
          mode_next = lfps_pkg::MODE_IDLE;
        end
      endcase
    end
    s1_next.mode = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= lfps_pkg::MODE_IDLE;
      white_run  <= '0;
      error_sum  <= '0;
      prev_error <= '0;
    end else if (accept) begin
      mode       <= mode_next;
      white_run  <= white_run_next;
      error_sum  <= error_sum_next;
      prev_error <= prev_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

endmodule

FILE: rtl/core/lfps_math.sv
module lfps_math #(
  parameter int SCALE_DIVISOR = lfps_pkg::SCALE_DIVISOR_DEF
) (
  input  logic                 clk,
  input  lfps_pkg::math_load_t load,
  input  lfps_pkg::cfg_t       cfg,
  input  lfps_pkg::s1_t        s1,
  output lfps_pkg::res_t       res
);

  // Division by the scale is a multiply by a rounded-up reciprocal, exact for
  // every magnitude below two to the MAG_W.
  localparam int RECIP_SHIFT = lfps_pkg::MAG_W + $clog2(SCALE_DIVISOR);
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + 64'(SCALE_DIVISOR) - 64'd1) / 64'(SCALE_DIVISOR);
  localparam logic [lfps_pkg::RECIP_W-1:0] RECIP = lfps_pkg::RECIP_W'(RECIP_FULL);

  localparam int TW = lfps_pkg::TERM_W;

  logic                    s2_pid;
  lfps_pkg::mode_t         s2_mode;
  logic signed [TW-1:0]    p_term;
  logic signed [TW-1:0]    i_term;
  logic signed [TW-1:0]    d_term;

  logic                    s3_pid;
  lfps_pkg::mode_t         s3_mode;
  logic signed [TW-1:0]    pid_sum;

  logic                    s4_pid;
  lfps_pkg::mode_t         s4_mode;
  logic                    s4_neg;
  logic [lfps_pkg::MAG_W-1:0] mag;

  logic                    s5_pid;
  lfps_pkg::mode_t         s5_mode;
  logic                    s5_neg;
  logic [lfps_pkg::PROD_W-1:0] prod;

  logic signed [TW-1:0]    err_ext;
  logic signed [TW-1:0]    sum_ext;
  logic signed [TW-1:0]    derr_ext;
  logic signed [TW-1:0]    pg;
  logic signed [TW-1:0]    ig;
  logic signed [TW-1:0]    dg;

  assign err_ext  = TW'(s1.err);
  assign sum_ext  = TW'(s1.sum);
  assign derr_ext = TW'(s1.derr);
  assign pg       = signed'(TW'(cfg.prop_gain));
  assign ig       = signed'(TW'(cfg.integ_gain));
  assign dg       = signed'(TW'(cfg.deriv_gain));

  always_ff @(posedge clk) begin
    if (load.s2) begin
      s2_pid  <= s1.pid;
      s2_mode <= s1.mode;
      p_term  <= err_ext * pg;
      i_term  <= sum_ext * ig;
      d_term  <= derr_ext * dg;
    end
    if (load.s3) begin
      s3_pid  <= s2_pid;
      s3_mode <= s2_mode;
      pid_sum <= p_term + i_term + d_term;
    end
    if (load.s4) begin
      s4_pid  <= s3_pid;
      s4_mode <= s3_mode;
      s4_neg  <= pid_sum[TW-1];
      mag     <= lfps_pkg::MAG_W'(pid_sum[TW-1] ? -pid_sum : pid_sum);
    end
    if (load.s5) begin
      s5_pid  <= s4_pid;
      s5_mode <= s4_mode;
      s5_neg  <= s4_neg;
      prod    <= lfps_pkg::PROD_W'(mag) * lfps_pkg::PROD_W'(RECIP);
    end
  end

  assign res.pid  = s5_pid;
  assign res.mode = s5_mode;
  assign res.neg  = s5_neg;
  assign res.quot = lfps_pkg::MAG_W'(prod >> RECIP_SHIFT);

endmodule

FILE: rtl/core/lfps_drive.sv
module lfps_drive (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [6:0]          base_speed,
  input  lfps_pkg::res_t      res,
  output logic signed [7:0]   left_drive,
  output logic signed [7:0]   right_drive,
  output logic [1:0]          run_state,
  output logic [1:0]          turn_dir
);

  localparam int DW = lfps_pkg::DRV_W;

  lfps_pkg::turn_t         last_turn;
  lfps_pkg::turn_t         last_turn_next;
  lfps_pkg::turn_t         turn;
  logic signed [DW-1:0]    base_ext;
  logic signed [DW-1:0]    quot_ext;
  logic signed [DW-1:0]    left_raw;
  logic signed [DW-1:0]    right_raw;
  logic signed [7:0]       left_clamped;
  logic signed [7:0]       right_clamped;
  logic signed [7:0]       left_next;
  logic signed [7:0]       right_next;

  function automatic logic signed [7:0] clamp_drive(input logic signed [DW-1:0] v);
    logic signed [7:0] r;
    if (v > DW'(lfps_pkg::DRIVE_MAX)) begin
      r = lfps_pkg::DRIVE_MAX;
    end else if (v < DW'(lfps_pkg::DRIVE_MIN)) begin
      r = lfps_pkg::DRIVE_MIN;
    end else begin
      r = 8'(v);
    end
    return r;
  endfunction

  assign base_ext      = signed'(DW'(base_speed));
  assign quot_ext      = signed'(DW'(res.quot));
  assign left_raw      = res.neg ? base_ext + quot_ext : base_ext - quot_ext;
  assign right_raw     = res.neg ? base_ext - quot_ext : base_ext + quot_ext;
  assign left_clamped  = clamp_drive(left_raw);
  assign right_clamped = clamp_drive(right_raw);

  always_comb begin
    if (res.quot < lfps_pkg::MAG_W'(lfps_pkg::TURN_DEADBAND)) begin
      turn = lfps_pkg::TURN_FWD;
    end else if (left_clamped > right_clamped) begin
      turn = lfps_pkg::TURN_RIGHT;
    end else begin
      turn = lfps_pkg::TURN_LEFT;
    end
  end

  always_comb begin
    if (res.pid) begin
      left_next      = left_clamped;
      right_next     = right_clamped;
      last_turn_next = turn;
    end else begin
      left_next      = '0;
      right_next     = '0;
      last_turn_next = last_turn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_turn <= lfps_pkg::TURN_FWD;
    end else if (load) begin
      last_turn <= last_turn_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_drive  <= left_next;
      right_drive <= right_next;
      run_state   <= res.mode;
      turn_dir    <= last_turn_next;
    end
  end

endmodule

FILE: rtl/core/line_follow_pid_steering_unit.sv
// Line-follow steering controller with a PID loop and a clamped integral.
// Input channel: in_valid/in_ready carry one transaction, either a pair of
// line-sensor samples (action low) or a start/stop toggle (action high).
// Output channel: out_valid/out_ready return exactly one transaction per
// input, in order, with both wheel drives, the run state and turn direction.
// Configuration: cfg_we writes cfg_data into register cfg_index;
// write only while no transaction is in flight.
// Throughput is one transaction per cycle while the receiver does not stall:
// mode and integral state update at acceptance, and the products, sum,
// magnitude, reciprocal scaling and clamp run in a five-stage pipeline
// behind it.
// Reset clears the mode to idle, the integral, last error and white-run
// count to zero, the turn direction to forward and the registers to their
// defaults; the pipeline is emptied.
// When the receiver stalls, results queue in the pipeline stages; in_ready
// drops only once every stage holds a transaction.
module line_follow_pid_steering_unit #(
  parameter int SCALE_DIVISOR = lfps_pkg::SCALE_DIVISOR_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        action,
  input  logic [7:0]                  left_sample,
  input  logic [7:0]                  right_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [7:0]           left_drive,
  output logic signed [7:0]           right_drive,
  output logic [1:0]                  run_state,
  output logic [1:0]                  turn_dir,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [lfps_pkg::CFG_W-1:0]  cfg_data
);

  lfps_pkg::cfg_t       cfg;
  lfps_pkg::mode_t      mode;
  lfps_pkg::s1_t        s1;
  lfps_pkg::res_t       res;
  lfps_pkg::math_load_t load;

  logic v1, v2, v3, v4, v5;
  logic rdy2, rdy3, rdy4, rdy5, rdy_out;
  logic accept;
  logic load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain   <= '0;
      cfg.integ_gain  <= '0;
      cfg.deriv_gain  <= '0;
      cfg.integ_limit <= lfps_pkg::INTEG_LIMIT_RST;
      cfg.base_speed  <= lfps_pkg::BASE_SPEED_RST;
      cfg.near_white  <= lfps_pkg::NEAR_WHITE_RST;
      cfg.near_black  <= lfps_pkg::NEAR_BLACK_RST;
      cfg.lost_limit  <= lfps_pkg::LOST_LIMIT_RST;
    end else if (cfg_we) begin
      case (lfps_pkg::cfg_index_t'(cfg_index))
        lfps_pkg::CFG_PROP_GAIN:   cfg.prop_gain   <= cfg_data[9:0];
        lfps_pkg::CFG_INTEG_GAIN:  cfg.integ_gain  <= cfg_data[9:0];
        lfps_pkg::CFG_DERIV_GAIN:  cfg.deriv_gain  <= cfg_data[9:0];
        lfps_pkg::CFG_INTEG_LIMIT: cfg.integ_limit <= cfg_data[14:0];
        lfps_pkg::CFG_BASE_SPEED:  cfg.base_speed  <= cfg_data[6:0];
        lfps_pkg::CFG_NEAR_WHITE:  cfg.near_white  <= cfg_data[7:0];
        lfps_pkg::CFG_NEAR_BLACK:  cfg.near_black  <= cfg_data[7:0];
        lfps_pkg::CFG_LOST_LIMIT:  cfg.lost_limit  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign rdy_out  = !out_valid || out_ready;
  assign rdy5     = !v5 || rdy_out;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign in_ready = !v1 || rdy2;
  assign accept   = in_valid && in_ready;

  assign load.s2  = v1 && rdy2;
  assign load.s3  = v2 && rdy3;
  assign load.s4  = v3 && rdy4;
  assign load.s5  = v4 && rdy5;
  assign load_out = v5 && rdy_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy5) begin
        v5 <= v4;
      end
      if (rdy_out) begin
        out_valid <= v5;
      end
    end
  end

  lfps_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .action       (action),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .cfg          (cfg),
    .mode         (mode),
    .s1           (s1)
  );

  lfps_math #(
    .SCALE_DIVISOR (SCALE_DIVISOR)
  ) u_math (
    .clk  (clk),
    .load (load),
    .cfg  (cfg),
    .s1   (s1),
    .res  (res)
  );

  lfps_drive u_drive (
    .clk         (clk),
    .rst         (rst),
    .load        (load_out),
    .base_speed  (cfg.base_speed),
    .res         (res),
    .left_drive  (left_drive),
    .right_drive (right_drive),
    .run_state   (run_state),
    .turn_dir    (turn_dir)
  );

`ifndef SYNTHESIS
  a_toggle_changes_mode: assert property (@(posedge clk) disable iff (rst)
    accept && action |=> mode != $past(mode))
    else $error("A toggle transaction did not change the mode.");

  a_zero_drive_off_track: assert property (@(posedge clk) disable iff (rst)
    out_valid && (run_state != lfps_pkg::MODE_TRACK) |-> (left_drive == 8'sd0) &&
    (right_drive == 8'sd0))
    else $error("Nonzero drive while idle or lost.");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_drive <= lfps_pkg::DRIVE_MAX) && (left_drive >= lfps_pkg::DRIVE_MIN) &&
    (right_drive <= lfps_pkg::DRIVE_MAX) && (right_drive >= lfps_pkg::DRIVE_MIN))
    else $error("Drive outside the allowed range.");

  a_full_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("Input stalled while the output was not stalled.");
`endif

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  import lfps_pkg::*;

  localparam int SCALE_DIV       = SCALE_DIVISOR_DEF;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int LONG_HOLD       = 60;
  localparam int DIR_ROWS_N      = 24;

  typedef struct packed {
    logic signed [7:0] left;
    logic signed [7:0] right;
    mode_t             st;
    turn_t             dir;
  } drive_t;

  typedef struct packed {
    logic [1:0]        setting;
    logic              act;
    logic [7:0]        ls;
    logic [7:0]        rs;
    logic              typed;
    logic signed [7:0] l;
    logic signed [7:0] r;
    mode_t             st;
    turn_t             dir;
  } step_row_t;

  localparam cfg_t DIR_CFG [3] = '{
    '{10'd0, 10'd0, 10'd0, INTEG_LIMIT_RST, BASE_SPEED_RST, NEAR_WHITE_RST,
      NEAR_BLACK_RST, LOST_LIMIT_RST},
    '{10'd1023, 10'd1023, 10'd1023, 15'd32767, 7'd100, 8'd255, 8'd0, 16'd0},
    '{10'd64, 10'd512, 10'd0, 15'd0, 7'd0, 8'd0, 8'd255, 16'd65534}
  };

  // Rows with typed set carry a result that follows directly from the row and
  // the settings in force; the others are checked against the predictor.
  localparam step_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{2'd0, 1'b0, 8'd0,   8'd0,   1'b1, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD},
    '{2'd0, 1'b0, 8'd255, 8'd255, 1'b1, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD},
    '{2'd0, 1'b1, 8'd0,   8'd0,   1'b1, 8'sd0,   8'sd0,   MODE_TRACK, TURN_FWD},
    '{2'd0, 1'b0, 8'd255, 8'd0,   1'b1, 8'sd30,  8'sd30,  MODE_TRACK, TURN_FWD},
    '{2'd0, 1'b0, 8'd0,   8'd255, 1'b1, 8'sd30,  8'sd30,  MODE_TRACK, TURN_FWD},
    '{2'd0, 1'b0, 8'd10,  8'd20,  1'b0, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD},
    '{2'd0, 1'b1, 8'd0,   8'd0,   1'b1, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD},
    '{2'd1, 1'b1, 8'd0,   8'd0,   1'b1, 8'sd0,   8'sd0,   MODE_TRACK, TURN_FWD},
    '{2'd0, 1'b0, 8'd255, 8'd0,   1'b1, -8'sd100, 8'sd100, MODE_TRACK, TURN_LEFT},
    '{2'd0, 1'b0, 8'd0,   8'd255, 1'b0, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD},
    '{2'd0, 1'b0, 8'd0,   8'd0,   1'b0, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD},
    '{2'd0, 1'b0, 8'd0,   8'd0,   1'b0, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD},
    '{2'd0, 1'b0, 8'd1,   8'd0,   1'b0, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD},
    '{2'd0, 1'b0, 8'd128, 8'd128, 1'b0, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD},
    '{2'd0, 1'b1, 8'd0,   8'd0,   1'b0, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD},
    '{2'd0, 1'b1, 8'd77,  8'd33,  1'b0, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD},
    '{2'd0, 1'b0, 8'd254, 8'd254, 1'b0, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD},
    '{2'd0, 1'b1, 8'd0,   8'd0,   1'b0, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD},
    '{2'd2, 1'b1, 8'd0,   8'd0,   1'b0, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD},
    '{2'd0, 1'b0, 8'd200, 8'd196, 1'b0, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD},
    '{2'd0, 1'b0, 8'd200, 8'd195, 1'b0, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD},
    '{2'd0, 1'b0, 8'd196, 8'd200, 1'b0, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD},
    '{2'd0, 1'b0, 8'd255, 8'd0,   1'b0, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD},
    '{2'd0, 1'b0, 8'd0,   8'd255, 1'b0, 8'sd0,   8'sd0,   MODE_IDLE,  TURN_FWD}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              action = 1'b0;
  logic [7:0]        left_sample = '0;
  logic [7:0]        right_sample = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [7:0] left_drive;
  logic signed [7:0] right_drive;
  logic [1:0]        run_state;
  logic [1:0]        turn_dir;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  cfg_t        regs = DIR_CFG[0];
  mode_t       trk_mode = MODE_IDLE;
  int unsigned white_cnt = 0;
  int          integ_acc = 0;
  int          last_err = 0;
  turn_t       heading = TURN_FWD;

  drive_t pending_drives[$];
  drive_t want;
  int     gap_pct = 20;
  int     stall_pct = 20;
  bit     long_hold_req = 1'b0;
  int     bad_results = 0;
  int     results_seen = 0;
  int     live_items = 0;
  int     sent_items = 0;
  int     settings_applied = 0;
  int     lost_entries = 0;
  int     regains = 0;
  int     input_stalls = 0;

  line_follow_pid_steering_unit #(
    .SCALE_DIVISOR(SCALE_DIV)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .left_drive   (left_drive),
    .right_drive  (right_drive),
    .run_state    (run_state),
    .turn_dir     (turn_dir),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int clamp_drive(input int v);
    if (v > 100) return 100;
    if (v < -100) return -100;
    return v;
  endfunction

  function automatic drive_t steer_predict(input logic act, input logic [7:0] ls,
                                           input logic [7:0] rs);
    drive_t res;
    int     err, lim, acc, pid, corr, mag, lft, rgt;
    res = '0;
    if (act) begin
      trk_mode = (trk_mode == MODE_IDLE) ? MODE_TRACK : MODE_IDLE;
      if (trk_mode == MODE_TRACK) white_cnt = 0;
    end else if (trk_mode == MODE_TRACK) begin
      if (ls < regs.near_white && rs < regs.near_white) begin
        if (white_cnt < 65535) white_cnt++;
        if (white_cnt > regs.lost_limit) begin
          trk_mode = MODE_LOST;
          lost_entries++;
        end
      end else begin
        white_cnt = 0;
      end
      if (trk_mode == MODE_TRACK) begin
        err = int'(ls) - int'(rs);
        lim = int'(regs.integ_limit);
        acc = integ_acc + err;
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
        integ_acc = acc;
        pid = err * int'(regs.prop_gain) + acc * int'(regs.integ_gain)
            + (err - last_err) * int'(regs.deriv_gain);
        corr = pid / SCALE_DIV;
        last_err = err;
        lft = clamp_drive(int'(regs.base_speed) - corr);
        rgt = clamp_drive(int'(regs.base_speed) + corr);
        mag = (corr < 0) ? -corr : corr;
        if (mag < TURN_DEADBAND) heading = TURN_FWD;
        else if (lft > rgt) heading = TURN_RIGHT;
        else heading = TURN_LEFT;
        res.left = lft[7:0];
        res.right = rgt[7:0];
      end
    end else if (trk_mode == MODE_LOST) begin
      if (ls > regs.near_black || rs > regs.near_black) begin
        trk_mode = MODE_TRACK;
        regains++;
      end
    end
    res.st = trk_mode;
    res.dir = heading;
    return res;
  endfunction

  function automatic logic [9:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 10'd0;
      1: return 10'd1023;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic cfg_t random_settings(input int ph);
    cfg_t s;
    s = '0;
    if (ph == 0) begin
      s = '{10'd1023, 10'd1023, 10'd1023, 15'd32767, 7'd100, 8'd255, 8'd255, 16'd65534};
    end else if (ph != 1) begin
      s.prop_gain = pick_gain();
      s.integ_gain = pick_gain();
      s.deriv_gain = pick_gain();
      case ($urandom_range(0, 3))
        0: s.integ_limit = 15'd0;
        1: s.integ_limit = 15'd32767;
        default: s.integ_limit = 15'($urandom_range(0, 2000));
      endcase
      case ($urandom_range(0, 3))
        0: s.base_speed = 7'd0;
        1: s.base_speed = 7'd100;
        default: s.base_speed = 7'($urandom_range(0, 100));
      endcase
      s.near_white = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(20, 120));
      s.near_black = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(140, 240));
      case ($urandom_range(0, 5))
        0: s.lost_limit = 16'd0;
        1: s.lost_limit = 16'd65534;
        default: s.lost_limit = 16'($urandom_range(1, 12));
      endcase
    end
    return s;
  endfunction

  task automatic apply_settings(input cfg_t s);
    cfg_index_t       idx;
    logic [CFG_W-1:0] val;
    idx = idx.first();
    repeat (8) begin
      case (idx)
        CFG_PROP_GAIN:   val = CFG_W'(s.prop_gain);
        CFG_INTEG_GAIN:  val = CFG_W'(s.integ_gain);
        CFG_DERIV_GAIN:  val = CFG_W'(s.deriv_gain);
        CFG_INTEG_LIMIT: val = CFG_W'(s.integ_limit);
        CFG_BASE_SPEED:  val = CFG_W'(s.base_speed);
        CFG_NEAR_WHITE:  val = CFG_W'(s.near_white);
        CFG_NEAR_BLACK:  val = CFG_W'(s.near_black);
        default:         val = CFG_W'(s.lost_limit);
      endcase
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      @(posedge clk);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
    regs = s;
    settings_applied++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic steer_item(input logic act, input logic [7:0] ls, input logic [7:0] rs,
                            input bit typed, input drive_t typed_res);
    drive_t pred;
    bit     live;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    left_sample <= ls;
    right_sample <= rs;
    @(posedge clk);
    while (!in_ready) begin
      input_stalls++;
      @(posedge clk);
    end
    live = act || trk_mode != MODE_IDLE;
    pred = steer_predict(act, ls, rs);
    pending_drives.push_back(typed ? typed_res : pred);
    sent_items++;
    if (live) live_items++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_drives.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("Unexpected transaction: left %0d right %0d state %0d turn %0d",
                   left_drive, right_drive, run_state, turn_dir);
      end else begin
        want = pending_drives.pop_front();
        if (want.left !== left_drive || want.right !== right_drive ||
            want.st !== run_state || want.dir !== turn_dir) begin
          bad_results++;
          if (bad_results <= 10)
            $display("Mismatch: expected left %0d right %0d state %0d turn %0d, got left %0d right %0d state %0d turn %0d",
                     want.left, want.right, want.st, want.dir,
                     left_drive, right_drive, run_state, turn_dir);
        end
      end
    end
  end

  initial begin : receiver
    int hold;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        hold = 0;
        while (hold < LONG_HOLD) begin
          @(posedge clk);
          hold++;
        end
        long_hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    step_row_t row;
    drive_t    typed_res;
    int        kind, run_len, start, base, delta;
    logic [7:0] ls, rs;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS_N; i++) begin
      row = DIR_ROWS[i];
      if (row.setting != 2'd0) begin
        settle();
        apply_settings(DIR_CFG[row.setting]);
      end
      typed_res = '{row.l, row.r, row.st, row.dir};
      steer_item(row.act, row.ls, row.rs, row.typed, typed_res);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      apply_settings(random_settings(ph));
      if (ph == RAND_PHASES - 1 || ph == 2) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      if (ph == 2) long_hold_req = 1'b1;
      start = live_items;
      while (live_items - start < ITEMS_PER_PHASE) begin
        kind = $urandom_range(0, 19);
        if (trk_mode == MODE_IDLE && $urandom_range(0, 4) != 0) kind = 0;
        if (kind == 0) begin
          steer_item(1'b1, 8'($urandom), 8'($urandom), 1'b0, '0);
        end else if (kind <= 2) begin
          steer_item(1'b0, 8'($urandom), 8'($urandom), 1'b0, '0);
        end else if (kind <= 6) begin
          // A run of floor readings on both sensors, which can be long enough to lose the line.
          run_len = $urandom_range(1, (regs.lost_limit <= 16) ? regs.lost_limit + 3 : 16);
          repeat (run_len) begin
            if (regs.near_white == 8'd0) begin
              ls = 8'($urandom);
              rs = 8'($urandom);
            end else begin
              ls = 8'($urandom_range(0, regs.near_white - 1));
              rs = 8'($urandom_range(0, regs.near_white - 1));
            end
            steer_item(1'b0, ls, rs, 1'b0, '0);
          end
        end else if (kind <= 8) begin
          ls = 8'($urandom);
          rs = 8'($urandom);
          if (regs.near_black != 8'd255) begin
            if ($urandom_range(0, 1) == 0) ls = 8'($urandom_range(regs.near_black + 1, 255));
            else rs = 8'($urandom_range(regs.near_black + 1, 255));
          end
          steer_item(1'b0, ls, rs, 1'b0, '0);
        end else begin
          base = $urandom_range(0, 255);
          delta = $urandom_range(0, 80) - 40;
          delta = base + delta;
          if (delta < 0) delta = 0;
          if (delta > 255) delta = 255;
          steer_item(1'b0, 8'(base), 8'(delta), 1'b0, '0);
        end
      end
    end

    settle();
    $display("Sent %0d transactions (%0d directed) under %0d register settings; %0d results checked.",
             sent_items, DIR_ROWS_N, settings_applied, results_seen);
    $display("Line lost %0d times and regained %0d times; input back-pressure held for %0d cycles.",
             lost_entries, regains, input_stalls);
    if (bad_results == 0 && pending_drives.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
